FILE: src/ucbb_pkg.sv
// ----------------------------------------------------------------------------
// ucbb_pkg
// Shared widths, codes, transaction types and the cubic coefficient table of
// the uniform cubic B-spline basis row core.
// ----------------------------------------------------------------------------
package ucbb_pkg;

   // Fixed point and sizing
   localparam int FRAC_BITS = 16;
   localparam int MAX_BASIS = 32;
   localparam int ONE_FX    = 1 << FRAC_BITS;

   // Port field widths
   localparam int SAMPLE_W    = 16;
   localparam int KNOT_W      = 5;
   localparam int OFFSET_W    = 16;
   localparam int SCALE_W     = 24;
   localparam int INDEX_W     = 5;
   localparam int VALUE_W     = FRAC_BITS + 1;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;

   // Internal widths
   localparam int COL_W   = $clog2(MAX_BASIS);
   localparam int DIFF_W  = SAMPLE_W + 1;
   localparam int UPROD_W = DIFF_W + SCALE_W + 1;
   localparam int U_W     = FRAC_BITS + 9;
   localparam int X_W     = FRAC_BITS + 10;
   localparam int XS_W    = FRAC_BITS + 3;
   localparam int ACC_W   = FRAC_BITS + 14;
   localparam int PROD_W  = ACC_W + XS_W + 1;
   localparam int COEF_W  = 9;

   // Divide by 12: drop two bits, then multiply by a reciprocal of 3
   localparam int DIV_IN_W  = FRAC_BITS + 2;
   localparam int RECIP_SH  = FRAC_BITS + 4;
   localparam int RECIP_W   = FRAC_BITS + 3;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Knot count limits
   localparam int NK_MAX_I = (MAX_BASIS - 2 < 30) ? MAX_BASIS - 2 : 30;
   localparam logic [KNOT_W-1:0] NK_MIN = KNOT_W'(4);
   localparam logic [KNOT_W-1:0] NK_MAX = KNOT_W'(NK_MAX_I);

   // Register reset values
   localparam logic [KNOT_W-1:0]   KNOT_COUNT_RST  = KNOT_W'(10);
   localparam logic [OFFSET_W-1:0] TIME_OFFSET_RST = '0;
   localparam logic [SCALE_W-1:0]  U_SCALE_RST     = SCALE_W'(65536);

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_KNOT_COUNT  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_TIME_OFFSET = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_U_SCALE     = CSR_INDEX_W'(2);

   // Basis function kinds
   typedef enum logic [1:0] {
      FN_B4,
      FN_B3,
      FN_B2,
      FN_MID
   } fn_kind_type;

   // One row waiting for the back end
   typedef struct packed {
      logic signed [U_W-1:0] u;
      logic signed [X_W-1:0] rev;
      logic [COL_W-1:0]      last_col;
   } q_entry_type;

   // One column issued to the evaluator
   typedef struct packed {
      fn_kind_type           kind;
      logic signed [X_W-1:0] x;
      logic [COL_W-1:0]      col;
      logic                  last;
   } col_cmd_type;

   // Cubic piece coefficients, times 12
   typedef struct packed {
      logic signed [COEF_W-1:0] c0;
      logic signed [COEF_W-1:0] c1;
      logic signed [COEF_W-1:0] c2;
      logic signed [COEF_W-1:0] c3;
   } coef_set_type;

   function automatic coef_set_type coef_make(input int a0, input int a1,
                                              input int a2, input int a3);
      coef_set_type c;
      c.c0 = COEF_W'(a0);
      c.c1 = COEF_W'(a1);
      c.c2 = COEF_W'(a2);
      c.c3 = COEF_W'(a3);
      return c;
   endfunction

   // Coefficients of piece seg of a function kind
   function automatic coef_set_type coef_lookup(input fn_kind_type kind,
                                                input logic [1:0] seg);
      coef_set_type c;
      c = '0;
      unique case (kind)
         FN_B4: begin
            c = coef_make(12, -36, 36, -12);
         end
         FN_B3: begin
            case (seg)
               2'd0:    c = coef_make(0, 36, -54, 21);
               2'd1:    c = coef_make(24, -36, 18, -3);
               default: c = '0;
            endcase
         end
         FN_B2: begin
            case (seg)
               2'd0:    c = coef_make(0, 0, 18, -11);
               2'd1:    c = coef_make(-18, 54, -36, 7);
               2'd2:    c = coef_make(54, -54, 18, -2);
               default: c = '0;
            endcase
         end
         FN_MID: begin
            unique case (seg)
               2'd0: c = coef_make(0, 0, 0, 2);
               2'd1: c = coef_make(8, -24, 24, -6);
               2'd2: c = coef_make(-88, 120, -48, 6);
               2'd3: c = coef_make(128, -96, 24, -2);
            endcase
         end
      endcase
      return c;
   endfunction

endpackage

FILE: src/uniform_cubic_bspline_basis_row_core.sv
// ----------------------------------------------------------------------------
// uniform_cubic_bspline_basis_row_core
// Evaluates one row of a clamped uniform cubic B-spline basis matrix per
// sample time, one column value per result transaction.
// ----------------------------------------------------------------------------
// Usage:
//   csr_*  : write knot_count (index 0), time_offset (1), u_scale (2, Q8.16)
//            while the core is idle; other indexes are ignored. Always ready.
//   req_*  : one sample time per transaction.
//   rsp_*  : knot_count+2 transactions per sample (knot count clamped to
//            4..30), column order, rsp_row_last on the final column; values
//            are Q1.16 in 0..65536.
// Path: an accepted sample is registered in intake and queued as a row; the
//   sequencer issues its columns into the evaluator, whose result register
//   drives rsp_*. Throughput: one column per cycle while the output is not
//   stalled, set by the column sequencer that issues one column a cycle into
//   the evaluator pipeline. A four-row queue lets intake run ahead.
// Reset: registers return to knot_count 10, time_offset 0, u_scale 65536;
//   queue and pipelines are emptied.
// Stall: while a result waits with rsp_ready low, evaluator and sequencer
//   hold; intake keeps accepting until the queue and its register are full.
// ----------------------------------------------------------------------------
module uniform_cubic_bspline_basis_row_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [ucbb_pkg::SAMPLE_W-1:0]      req_sample_time,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [ucbb_pkg::INDEX_W-1:0]       rsp_basis_index,
   output logic [ucbb_pkg::VALUE_W-1:0]       rsp_basis_value,
   output logic                               rsp_row_last,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ucbb_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ucbb_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ucbb_pkg::*;

   logic         push_valid;
   logic         push_ready;
   q_entry_type  push_entry;
   logic         head_valid;
   logic         head_pop;
   q_entry_type  head;
   logic         adv;
   logic         cmd_valid;
   col_cmd_type  cmd;

   ucbb_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample_time (req_sample_time),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_entry      (push_entry)
   );

   ucbb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (head_valid),
      .pop_ready  (head_pop),
      .pop_entry  (head)
   );

   ucbb_colseq u_colseq (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .head       (head),
      .adv        (adv),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd)
   );

   ucbb_eval u_eval (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .adv             (adv),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_basis_index (rsp_basis_index),
      .rsp_basis_value (rsp_basis_value),
      .rsp_row_last    (rsp_row_last)
   );

endmodule

FILE: src/ucbb_front.sv
// ----------------------------------------------------------------------------
// ucbb_front
// Register file and sample intake: maps each sample time to the knot
// coordinate u and its mirror, then hands the row to the queue.
// ----------------------------------------------------------------------------
module ucbb_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [ucbb_pkg::SAMPLE_W-1:0]        req_sample_time,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ucbb_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ucbb_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic                                 push_valid,
   input  logic                                 push_ready,
   output ucbb_pkg::q_entry_type                push_entry
);
   import ucbb_pkg::*;

   localparam logic signed [UPROD_W-1:0] U_HI = UPROD_W'((1 << (FRAC_BITS + 8)) - 1);
   localparam logic signed [UPROD_W-1:0] U_LO = -U_HI - UPROD_W'(1);

   logic [KNOT_W-1:0]            knot_count_ff;
   logic [OFFSET_W-1:0]          time_offset_ff;
   logic [SCALE_W-1:0]           u_scale_ff;
   logic                         uprod_valid_ff;
   logic                         uprod_valid_in;
   logic signed [UPROD_W-1:0]    uprod_ff;
   logic signed [UPROD_W-1:0]    uprod_in;
   logic signed [DIFF_W-1:0]     diff;
   logic signed [UPROD_W-1:0]    u_wide;
   logic signed [U_W-1:0]        u_sat;
   logic [KNOT_W-1:0]            nk;
   logic signed [X_W-1:0]        rev_base;
   logic                         req_fire;

   assign csr_ready = 1'b1;

   // Configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         knot_count_ff  <= KNOT_COUNT_RST;
         time_offset_ff <= TIME_OFFSET_RST;
         u_scale_ff     <= U_SCALE_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_KNOT_COUNT:  knot_count_ff  <= csr_wdata[KNOT_W-1:0];
            CSR_TIME_OFFSET: time_offset_ff <= csr_wdata[OFFSET_W-1:0];
            CSR_U_SCALE:     u_scale_ff     <= csr_wdata[SCALE_W-1:0];
            default:         ;
         endcase
      end
   end

   // Scale the offset sample time
   assign req_ready      = !uprod_valid_ff || push_ready;
   assign req_fire       = req_valid && req_ready;
   assign diff           = $signed({1'b0, req_sample_time}) - $signed({1'b0, time_offset_ff});
   assign uprod_in       = diff * $signed({1'b0, u_scale_ff});
   assign uprod_valid_in = req_fire || (uprod_valid_ff && !push_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         uprod_valid_ff <= 1'b0;
      end else begin
         uprod_valid_ff <= uprod_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         uprod_ff <= uprod_in;
      end
   end

   // Floor to knot units, saturate, and clamp the knot count
   always_comb begin
      u_wide = uprod_ff >>> FRAC_BITS;
      if (u_wide < U_LO) begin
         u_sat = U_W'(U_LO);
      end else if (u_wide > U_HI) begin
         u_sat = U_W'(U_HI);
      end else begin
         u_sat = U_W'(u_wide);
      end
      priority if (knot_count_ff < NK_MIN) begin
         nk = NK_MIN;
      end else if (knot_count_ff > NK_MAX) begin
         nk = NK_MAX;
      end else begin
         nk = knot_count_ff;
      end
      rev_base = $signed(X_W'(nk - KNOT_W'(1))) <<< FRAC_BITS;
   end

   assign push_valid          = uprod_valid_ff;
   assign push_entry.u        = u_sat;
   assign push_entry.rev      = rev_base - X_W'(u_sat);
   assign push_entry.last_col = COL_W'(nk) + COL_W'(1);

endmodule

FILE: src/ucbb_queue.sv
// ----------------------------------------------------------------------------
// ucbb_queue
// Small row queue between intake and column evaluation.
// ----------------------------------------------------------------------------
module ucbb_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  ucbb_pkg::q_entry_type push_entry,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output ucbb_pkg::q_entry_type pop_entry
);
   import ucbb_pkg::*;

   q_entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;
   logic                push_fire;
   logic                pop_fire;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push_fire ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop_fire ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire && !pop_fire) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: src/ucbb_colseq.sv
// ----------------------------------------------------------------------------
// ucbb_colseq
// Column sequencer: walks the columns of the head row, picks the basis
// function and its argument for each, and retires the row on its last column.
// ----------------------------------------------------------------------------
module ucbb_colseq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   output logic                  head_pop,
   input  ucbb_pkg::q_entry_type head,
   input  logic                  adv,
   output logic                  cmd_valid,
   output ucbb_pkg::col_cmd_type cmd
);
   import ucbb_pkg::*;

   logic [COL_W-1:0] col_ff;
   logic [COL_W-1:0] col_in;
   logic             cmd_valid_ff;
   col_cmd_type      cmd_ff;
   col_cmd_type      cmd_in;
   logic             issue;

   assign issue    = head_valid && adv;
   assign head_pop = issue && cmd_in.last;

   // Pick function kind and argument for the current column
   always_comb begin
      cmd_in.col  = col_ff;
      cmd_in.last = (col_ff == head.last_col);
      priority if (col_ff == COL_W'(0)) begin
         cmd_in.kind = FN_B4;
         cmd_in.x    = X_W'(head.u);
      end else if (col_ff == COL_W'(1)) begin
         cmd_in.kind = FN_B3;
         cmd_in.x    = X_W'(head.u);
      end else if (col_ff == COL_W'(2)) begin
         cmd_in.kind = FN_B2;
         cmd_in.x    = X_W'(head.u);
      end else if (col_ff == head.last_col) begin
         cmd_in.kind = FN_B4;
         cmd_in.x    = head.rev;
      end else if (col_ff == head.last_col - COL_W'(1)) begin
         cmd_in.kind = FN_B3;
         cmd_in.x    = head.rev;
      end else if (col_ff == head.last_col - COL_W'(2)) begin
         cmd_in.kind = FN_B2;
         cmd_in.x    = head.rev;
      end else begin
         cmd_in.kind = FN_MID;
         cmd_in.x    = X_W'(head.u)
                       - ($signed(X_W'(col_ff - COL_W'(3))) <<< FRAC_BITS);
      end
      col_in = cmd_in.last ? '0 : col_ff + COL_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         cmd_valid_ff <= 1'b0;
      end else if (adv) begin
         cmd_valid_ff <= head_valid;
         if (head_valid) begin
            col_ff <= col_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         cmd_ff <= cmd_in;
      end
   end

   assign cmd_valid = cmd_valid_ff;
   assign cmd       = cmd_ff;

endmodule

FILE: src/ucbb_eval.sv
// ----------------------------------------------------------------------------
// ucbb_eval
// Cubic evaluator: support check and coefficient fetch, Horner in registered
// multiply and add steps, rounded divide by 12, saturation and result register.
// ----------------------------------------------------------------------------
module ucbb_eval (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           cmd_valid,
   input  ucbb_pkg::col_cmd_type          cmd,
   output logic                           adv,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [ucbb_pkg::INDEX_W-1:0]   rsp_basis_index,
   output logic [ucbb_pkg::VALUE_W-1:0]   rsp_basis_value,
   output logic                           rsp_row_last
);
   import ucbb_pkg::*;

   localparam logic signed [X_W-1:0]   ZERO_X   = '0;
   localparam logic signed [X_W-1:0]   ONE_X    = X_W'(ONE_FX);
   localparam logic signed [X_W-1:0]   TWO_X    = X_W'(2 * ONE_FX);
   localparam logic signed [X_W-1:0]   THREE_X  = X_W'(3 * ONE_FX);
   localparam logic signed [X_W-1:0]   FOUR_X   = X_W'(4 * ONE_FX);
   localparam logic signed [ACC_W-1:0] HALF_12  = ACC_W'(6);
   localparam logic signed [ACC_W-1:0] OVER_LIM = ACC_W'(12 * (ONE_FX + 1));
   localparam logic [RECIP_W-1:0]      RECIP    = RECIP_W'(((1 << RECIP_SH) + 2) / 3);
   localparam logic [VALUE_W-1:0]      ONE_V    = VALUE_W'(ONE_FX);

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic             last;
      logic             live;
   } tag_type;

   logic [7:1]                  vld_ff;
   logic [7:1]                  vld_in;
   tag_type                     tag_ff   [1:7];
   tag_type                     tag_in;
   coef_set_type                coef_ff  [1:5];
   logic [XS_W-1:0]             xs_ff    [1:4];
   logic signed [ACC_W-1:0]     acc1_ff;
   logic signed [ACC_W-1:0]     acc1_in;
   logic signed [PROD_W-1:0]    prod2_ff;
   logic signed [PROD_W-1:0]    prod2_in;
   logic signed [ACC_W-1:0]     acc2_ff;
   logic signed [ACC_W-1:0]     acc2_in;
   logic signed [PROD_W-1:0]    prod3_ff;
   logic signed [PROD_W-1:0]    prod3_in;
   logic signed [ACC_W-1:0]     acc3_ff;
   logic signed [ACC_W-1:0]     acc3_in;
   logic [VALUE_W-1:0]          q_ff;
   logic                        neg_ff;
   logic                        over_ff;
   logic [DIV_IN_W+RECIP_W-1:0] qprod;
   logic                        rsp_valid_ff;
   logic [INDEX_W-1:0]          rsp_index_ff;
   logic [VALUE_W-1:0]          rsp_value_ff;
   logic [VALUE_W-1:0]          rsp_value_in;
   logic                        rsp_last_ff;
   logic signed [X_W-1:0]       xm1;
   logic                        live1;
   logic [1:0]                  seg1;

   // Whole pipeline holds while a result waits
   assign adv    = !rsp_valid_ff || rsp_ready;
   assign vld_in = {vld_ff[6:1], cmd_valid};

   // Support test and piece select
   always_comb begin
      xm1  = cmd.x - X_W'(1);
      seg1 = xm1[FRAC_BITS+1:FRAC_BITS];
      unique case (cmd.kind)
         FN_B4: begin
            live1 = (cmd.x >= ZERO_X) && (cmd.x <= ONE_X);
            seg1  = 2'd0;
         end
         FN_B3:  live1 = (cmd.x > ZERO_X) && (cmd.x <= TWO_X);
         FN_B2:  live1 = (cmd.x > ZERO_X) && (cmd.x <= THREE_X);
         FN_MID: live1 = (cmd.x > ZERO_X) && (cmd.x <= FOUR_X);
      endcase
      tag_in.col  = cmd.col;
      tag_in.last = cmd.last;
      tag_in.live = live1;
   end

   // Horner steps, each product floored back to the fraction grid
   assign acc1_in  = coef_ff[1].c3 * $signed({1'b0, xs_ff[1]})
                     + ($signed(ACC_W'(coef_ff[1].c2)) <<< FRAC_BITS);
   assign prod2_in = acc1_ff * $signed({1'b0, xs_ff[2]});
   assign acc2_in  = ACC_W'(prod2_ff >>> FRAC_BITS)
                     + ($signed(ACC_W'(coef_ff[3].c1)) <<< FRAC_BITS);
   assign prod3_in = acc2_ff * $signed({1'b0, xs_ff[4]});
   assign acc3_in  = ACC_W'(prod3_ff >>> FRAC_BITS)
                     + ($signed(ACC_W'(coef_ff[5].c0)) <<< FRAC_BITS) + HALF_12;

   // Divide by 12 as divide by 4 then reciprocal of 3
   assign qprod = acc3_ff[DIV_IN_W+1:2] * RECIP;

   // Clamp to 0 .. 1.0; outside support the value is zero
   always_comb begin
      if (!tag_ff[7].live || neg_ff) begin
         rsp_value_in = '0;
      end else if (over_ff) begin
         rsp_value_in = ONE_V;
      end else begin
         rsp_value_in = q_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= vld_ff[7];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tag_ff[1]  <= tag_in;
         coef_ff[1] <= coef_lookup(cmd.kind, seg1);
         xs_ff[1]   <= cmd.x[XS_W-1:0];
         for (int i = 2; i <= 7; i++) begin
            tag_ff[i] <= tag_ff[i-1];
         end
         for (int i = 2; i <= 5; i++) begin
            coef_ff[i] <= coef_ff[i-1];
         end
         for (int i = 2; i <= 4; i++) begin
            xs_ff[i] <= xs_ff[i-1];
         end
         acc1_ff      <= acc1_in;
         prod2_ff     <= prod2_in;
         acc2_ff      <= acc2_in;
         prod3_ff     <= prod3_in;
         acc3_ff      <= acc3_in;
         q_ff         <= qprod[RECIP_SH+VALUE_W-1:RECIP_SH];
         neg_ff       <= acc3_ff[ACC_W-1];
         over_ff      <= (acc3_ff >= OVER_LIM);
         rsp_index_ff <= INDEX_W'(tag_ff[7].col);
         rsp_last_ff  <= tag_ff[7].last;
         rsp_value_ff <= rsp_value_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_basis_index = rsp_index_ff;
   assign rsp_basis_value = rsp_value_ff;
   assign rsp_row_last    = rsp_last_ff;

endmodule
